/* sv/mapg_pkg.sv */
// ---------------------------------------------------------------------------
// mapg_pkg
// Shared types and constants for the moving-average position gate.
// ---------------------------------------------------------------------------
package mapg_pkg;

  localparam int COORD_BITS  = 24;
  localparam int MAX_HISTORY = 16;
  localparam int HIST_IW     = 4;
  localparam int CNT_W       = 5;
  localparam int SCORE_W     = 16;
  localparam int CONF_W      = 17;
  localparam int SUM_W       = COORD_BITS + HIST_IW;
  localparam int DIFF_W      = COORD_BITS + 6;
  localparam int MAG_W       = DIFF_W - 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int RAD_W       = 60;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int DVD_W       = 31;
  localparam int IN_DATA_W   = 88;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 96;
  localparam int OUT_USER_W  = 3;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 24;

  localparam logic [CFG_AW-1:0] CFG_ACC_SCORE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_DIV_LIMIT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HIST_TERM = 2'd2;

  typedef enum logic [1:0] {
    OUTC_OK   = 2'd0,
    OUTC_NONE = 2'd1,
    OUTC_POOR = 2'd2,
    OUTC_FAR  = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_SCALE_WAIT,
    ST_DECIDE,
    ST_CONF_WAIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic sum_step;
    logic sq_step;
    logic root_start;
    logic div_start_root;
    logic div_start_conf;
    logic div_store;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic usable;
    logic n_zero;
    logic frame_end;
    logic sum_last;
    logic sq_last;
    logic root_done;
    logic div_done;
    logic out_busy;
    logic need_conf;
  } sts_t;

endpackage

/* sv/mapg_div.sv */
// ---------------------------------------------------------------------------
// mapg_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mapg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mapg_pkg::DVD_W-1:0]     dividend,
  input  logic [mapg_pkg::SCORE_W-1:0]   divisor,
  output logic                           done,
  output logic [mapg_pkg::DVD_W-1:0]     quot
);
  import mapg_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [4:0]          cnt_r;
  logic [SCORE_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]    q_r, q_nxt;
  logic [SCORE_W-1:0]  dsr_r;
  logic [SCORE_W:0]    sh;
  logic                ge;

  always_comb begin
    sh      = {rem_r, q_r[DVD_W-1]};
    ge      = sh >= {1'b0, dsr_r};
    rem_nxt = ge ? SCORE_W'(sh - {1'b0, dsr_r}) : sh[SCORE_W-1:0];
    q_nxt   = {q_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* sv/mapg_sqrt.sv */
// ---------------------------------------------------------------------------
// mapg_sqrt
// Integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module mapg_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mapg_pkg::RAD_W-1:0]   rad,
  output logic                         done,
  output logic [mapg_pkg::ROOT_W-1:0]  root
);
  import mapg_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [4:0]          cnt_r;
  logic [RAD_W-1:0]    rad_r;
  logic [ROOT_W+1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [ROOT_W+3:0]   sh;
  logic [ROOT_W+3:0]   trial;
  logic                ge;

  always_comb begin
    sh       = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = sh >= trial;
    rem_nxt  = ge ? (ROOT_W+2)'(sh - trial) : sh[ROOT_W+1:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* sv/mapg_dp.sv */
// ---------------------------------------------------------------------------
// mapg_dp
// Datapath: registers, history, best pick, distance units, result register.
// ---------------------------------------------------------------------------
module mapg_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mapg_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [mapg_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                             in_tlast,
  input  logic                             cfg_we,
  input  logic [mapg_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [mapg_pkg::CFG_DW-1:0]      cfg_wdata,
  input  mapg_pkg::cmd_t                   cmd,
  output mapg_pkg::sts_t                   sts,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [mapg_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [mapg_pkg::OUT_USER_W-1:0]  out_tuser
);
  import mapg_pkg::*;

  logic [SCORE_W-1:0]    acc_r;
  logic [COORD_BITS-1:0] lim_r;
  logic [CNT_W-1:0]      term_r;
  logic [CNT_W-1:0]      term_eff;

  logic signed [COORD_BITS-1:0] hx_r [MAX_HISTORY];
  logic signed [COORD_BITS-1:0] hy_r [MAX_HISTORY];
  logic signed [COORD_BITS-1:0] hz_r [MAX_HISTORY];
  logic [CNT_W-1:0]      hcnt_r;

  logic                  bvalid_r;
  logic [SCORE_W-1:0]    bscore_r;
  logic signed [COORD_BITS-1:0] bx_r, by_r, bz_r;
  logic [COORD_BITS-1:0] bdiv_r;
  logic                  last_r, none_r, usable_r;

  logic [CNT_W-1:0]      n_r;
  logic [HIST_IW-1:0]    idx_r;
  logic signed [SUM_W-1:0] sx_r, sy_r, sz_r;
  logic [2:0]            sq_idx_r;
  logic [MAG_W-1:0]      mag_r;
  logic [SQ_W-1:0]       prod_r;
  logic [RAD_W-1:0]      dsq_r;

  logic                  oval_r;
  logic [OUT_DATA_W-1:0] odata_r;
  logic [OUT_USER_W-1:0] ouser_r;

  // input decode
  logic signed [COORD_BITS-1:0] i_x, i_y, i_z;
  logic [SCORE_W-1:0]    i_score;
  logic                  i_conv, i_none;
  logic [SCORE_W-1:0]    bound;
  logic                  usable;
  logic [CNT_W-1:0]      n_calc;

  assign i_x     = in_tdata[23:0];
  assign i_y     = in_tdata[47:24];
  assign i_z     = in_tdata[71:48];
  assign i_score = in_tdata[87:72];
  assign i_conv  = in_tuser[0];
  assign i_none  = in_tuser[1];
  assign bound   = bvalid_r ? bscore_r : '1;
  assign usable  = !i_none && i_conv && (i_score < bound);

  always_comb begin
    if (term_r == '0) term_eff = CNT_W'(1);
    else if (term_r > CNT_W'(MAX_HISTORY)) term_eff = CNT_W'(MAX_HISTORY);
    else term_eff = term_r;
    n_calc = (hcnt_r > term_eff) ? term_eff : hcnt_r;
  end

  // distance arithmetic
  logic signed [COORD_BITS-1:0] t_sel;
  logic signed [SUM_W-1:0]      s_sel;
  logic signed [DIFF_W-1:0]     nt, diff;
  logic [MAG_W-1:0]             mag;

  always_comb begin
    case (sq_idx_r)
      3'd0:    begin t_sel = bx_r; s_sel = sx_r; end
      3'd1:    begin t_sel = by_r; s_sel = sy_r; end
      default: begin t_sel = bz_r; s_sel = sz_r; end
    endcase
    nt   = $signed({{(DIFF_W-CNT_W){1'b0}}, n_r})
         * $signed({{(DIFF_W-COORD_BITS){t_sel[COORD_BITS-1]}}, t_sel});
    diff = nt - $signed({{(DIFF_W-SUM_W){s_sel[SUM_W-1]}}, s_sel});
    mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  end

  // arithmetic units (divider shared by scale and confidence)
  logic                 root_done, div_done;
  logic [ROOT_W-1:0]    root;
  logic [DVD_W-1:0]     quot, dvd;
  logic [SCORE_W-1:0]   dsr;

  assign dvd = cmd.div_start_conf ? {acc_r, 15'b0} : {1'b0, root};
  assign dsr = cmd.div_start_conf ? bscore_r : {{(SCORE_W-CNT_W){1'b0}}, n_r};

  mapg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_start),
    .rad   (dsq_r),
    .done  (root_done),
    .root  (root)
  );

  mapg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start_root | cmd.div_start_conf),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quot     (quot)
  );

  // frame decision
  logic     acc_ok, far, found, conf_one, push;
  outcome_t outc;
  logic [CONF_W-1:0] conf;

  always_comb begin
    acc_ok   = bvalid_r && (bscore_r <= acc_r);
    far      = bdiv_r >= lim_r;
    found    = !none_r && acc_ok && !far;
    push     = !none_r && acc_ok;
    conf_one = (bscore_r == '0) || ({bscore_r, 1'b0} < {1'b0, acc_r});
    if (none_r || !bvalid_r) outc = OUTC_NONE;
    else if (!acc_ok) outc = OUTC_POOR;
    else if (far) outc = OUTC_FAR;
    else outc = OUTC_OK;
    if (!found) conf = '0;
    else if (conf_one) conf = CONF_W'(65536);
    else conf = quot[CONF_W-1:0];
  end

  always_comb begin
    sts.usable    = usable_r;
    sts.n_zero    = (n_r == '0);
    sts.frame_end = last_r || none_r;
    sts.sum_last  = ({1'b0, idx_r} == CNT_W'(n_r - CNT_W'(1)));
    sts.sq_last   = (sq_idx_r == 3'd4);
    sts.root_done = root_done;
    sts.div_done  = div_done;
    sts.out_busy  = oval_r;
    sts.need_conf = found && !conf_one;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= SCORE_W'(49);
      lim_r    <= COORD_BITS'(8192);
      term_r   <= CNT_W'(10);
      hcnt_r   <= '0;
      bvalid_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ACC_SCORE: acc_r  <= cfg_wdata[SCORE_W-1:0];
          CFG_DIV_LIMIT: lim_r  <= cfg_wdata[COORD_BITS-1:0];
          CFG_HIST_TERM: term_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_in && usable) bvalid_r <= 1'b1;
      if (oval_r && out_tready) oval_r <= 1'b0;
      if (cmd.finish) begin
        bvalid_r <= 1'b0;
        oval_r   <= 1'b1;
        if (push) hcnt_r <= (hcnt_r < term_eff) ? hcnt_r + CNT_W'(1) : term_eff;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      last_r   <= in_tlast;
      none_r   <= i_none;
      usable_r <= usable;
      n_r      <= n_calc;
      idx_r    <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      sz_r     <= '0;
      sq_idx_r <= '0;
      dsq_r    <= '0;
      if (usable) begin
        bscore_r <= i_score;
        bx_r     <= i_x;
        by_r     <= i_y;
        bz_r     <= i_z;
        bdiv_r   <= '0;
      end
    end
    if (cmd.sum_step) begin
      sx_r  <= sx_r + SUM_W'(hx_r[idx_r]);
      sy_r  <= sy_r + SUM_W'(hy_r[idx_r]);
      sz_r  <= sz_r + SUM_W'(hz_r[idx_r]);
      idx_r <= idx_r + HIST_IW'(1);
    end
    // abs diff, square and accumulate run as three stages per axis
    if (cmd.sq_step) begin
      mag_r  <= mag;
      prod_r <= mag_r * mag_r;
      if (sq_idx_r >= 3'd2) dsq_r <= dsq_r + RAD_W'(prod_r);
      sq_idx_r <= sq_idx_r + 3'd1;
    end
    if (cmd.div_store) begin
      bdiv_r <= (quot[DVD_W-1:COORD_BITS] != '0) ? '1 : quot[COORD_BITS-1:0];
    end
    if (cmd.finish && push) begin
      for (int i = 0; i < MAX_HISTORY; i++) begin
        if (i == 0) begin
          hx_r[i] <= bx_r;
          hy_r[i] <= by_r;
          hz_r[i] <= bz_r;
        end else if (CNT_W'(i) < term_eff) begin
          hx_r[i] <= hx_r[i-1];
          hy_r[i] <= hy_r[i-1];
          hz_r[i] <= hz_r[i-1];
        end
      end
    end
    if (cmd.finish) begin
      odata_r <= {7'b0, conf,
                  found ? bz_r : COORD_BITS'(0),
                  found ? by_r : COORD_BITS'(0),
                  found ? bx_r : COORD_BITS'(0)};
      ouser_r <= {outc, found};
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

/* sv/mapg_ctrl.sv */
// ---------------------------------------------------------------------------
// mapg_ctrl
// Sequencer: steps one transaction through check, sum, square, root, scale, decide.
// ---------------------------------------------------------------------------
module mapg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output mapg_pkg::cmd_t   cmd,
  input  mapg_pkg::sts_t   sts
);
  import mapg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.usable && !sts.n_zero) state_nxt = ST_SUM;
        else if (sts.frame_end) state_nxt = ST_DECIDE;
        else state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) state_nxt = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sts.root_done) begin
          cmd.div_start_root = 1'b1;
          state_nxt          = ST_SCALE_WAIT;
        end
      end
      ST_SCALE_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = sts.frame_end ? ST_DECIDE : ST_IDLE;
        end
      end
      ST_DECIDE: begin
        if (!sts.out_busy) begin
          if (sts.need_conf) begin
            cmd.div_start_conf = 1'b1;
            state_nxt          = ST_CONF_WAIT;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_CONF_WAIT: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/moving_average_position_gate.sv */
// ---------------------------------------------------------------------------
// moving_average_position_gate
// Gates per-frame object position picks against a moving-average history.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tdata x,y,z,score; tuser converged,no_cand
// out_     out  tvalid/tready      tdata x,y,z,confidence; tuser found,outcome
// cfg_     in   we                 addr, wdata
//
// One transaction at a time; each is accepted and then checked. A candidate that
// replaces the pick runs the history sum over the n averaged entries, the squares,
// the bit-serial root and the scaling divide (all skipped when n is 0). A frame
// end adds a decide step and, when the confidence is not above one, its divide.
// Synchronous active-low reset; a pending result holds only the decide step.
// ---------------------------------------------------------------------------
module moving_average_position_gate (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mapg_pkg::IN_DATA_W-1:0]   in_tdata,   // pos_x, pos_y, pos_z, fit_score
  input  logic [mapg_pkg::IN_USER_W-1:0]   in_tuser,   // converged, no_candidate
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mapg_pkg::OUT_DATA_W-1:0]  out_tdata,  // obj_x, obj_y, obj_z, confidence
  output logic [mapg_pkg::OUT_USER_W-1:0]  out_tuser,  // found, outcome
  input  logic                             cfg_we,
  input  logic [mapg_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [mapg_pkg::CFG_DW-1:0]      cfg_wdata
);
  import mapg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mapg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mapg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
